>>> hdl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Shared types, codes and saturation helpers for the rain/evaporation/clamp
// cell update.
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int unsigned LevelW  = 32;
  localparam int unsigned WeightW = 17;
  localparam int unsigned VolW    = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RAIN_RATE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_EVAP_RATE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DEPTH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CELL_AREA = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_EVAP_MODE = 3'd5;

  localparam logic [30:0] CellAreaReset = 31'd65536;

  // Operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RAIN_STEP,
    MUL_RAIN_W,
    MUL_EVAP_STEP,
    MUL_RAIN_VOL,
    MUL_EVAP_W,
    MUL_EVAP_VOL,
    MUL_CLAMP_VOL
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     ld_eta1;
    logic     ld_ed;
    logic     upd_rain;
    logic     ld_eta2;
    logic     upd_evap;
    logic     finish;
  } srec_cmd_t;

  typedef struct packed {
    logic out_busy;
  } srec_sts_t;

  localparam logic signed [65:0] Sat32Max = 66'sd2147483647;
  localparam logic signed [65:0] Sat32Min = -66'sd2147483648;
  localparam logic signed [64:0] Sat64Max = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] Sat64Min = 65'sh1_8000_0000_0000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > Sat32Max) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < Sat32Min) begin
      r = 32'sh8000_0000;
    end else begin
      r = signed'(x[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                  input logic signed [48:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s > Sat64Max) begin
      r = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (s < Sat64Min) begin
      r = 64'sh8000_0000_0000_0000;
    end else begin
      r = signed'(s[63:0]);
    end
    return r;
  endfunction

endpackage

>>> hdl/srec_if.sv
// ----------------------------------------------------------------------------
// srec_in_if / srec_out_if
// Valid/ready channels carrying one cell word in and one result word out.
// ----------------------------------------------------------------------------
interface srec_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [srec_pkg::LevelW-1:0]    surface_level;
  logic signed [srec_pkg::LevelW-1:0]    bed_level;
  logic        [srec_pkg::WeightW-1:0]   rain_weight;
  logic        [srec_pkg::WeightW-1:0]   evap_weight;

  modport source (output valid, surface_level, bed_level, rain_weight, evap_weight,
                  input ready);
  modport sink (input valid, surface_level, bed_level, rain_weight, evap_weight,
                output ready);
endinterface

interface srec_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [srec_pkg::LevelW-1:0]    new_surface_level;
  logic signed [srec_pkg::VolW-1:0]      rain_volume;
  logic signed [srec_pkg::VolW-1:0]      evap_volume;
  logic signed [srec_pkg::VolW-1:0]      clamp_volume;

  modport source (output valid, new_surface_level, rain_volume, evap_volume,
                  clamp_volume, input ready);
  modport sink (input valid, new_surface_level, rain_volume, evap_volume,
                clamp_volume, output ready);
endinterface

>>> hdl/surface_rain_evap_clamp.sv
// ----------------------------------------------------------------------------
// surface_rain_evap_clamp
// Per-cell rain, evaporation and dry clamp with saturating volume totals.
// ----------------------------------------------------------------------------
// One cell word is taken when in_ch.ready is high, which is only while the
// block has no cell in flight; a cell occupies it until its result word is
// loaded into the output register. It runs through one shared 33x32 multiplier
// used seven times per cell (two step depths, two weighted depths, three
// volumes), each product registered before use. The result word sits in an
// output register, so the next cell is accepted while it waits. Write the
// configuration only while idle; cell_area resets to 1.0, all else to zero.
// ----------------------------------------------------------------------------
module surface_rain_evap_clamp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srec_in_if.sink                      in_ch,
  srec_out_if.source                   out_ch,
  input  logic                         cfg_we_i,
  input  logic [srec_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [srec_pkg::CfgW-1:0]    cfg_data_i
);

  srec_pkg::srec_cmd_t cmd;
  srec_pkg::srec_sts_t sts;

  srec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srec_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .surface_level_i     (in_ch.surface_level),
    .bed_level_i         (in_ch.bed_level),
    .rain_weight_i       (in_ch.rain_weight),
    .evap_weight_i       (in_ch.evap_weight),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_ch.valid),
    .out_ready_i         (out_ch.ready),
    .new_surface_level_o (out_ch.new_surface_level),
    .rain_volume_o       (out_ch.rain_volume),
    .evap_volume_o       (out_ch.evap_volume),
    .clamp_volume_o      (out_ch.clamp_volume)
  );

endmodule

>>> hdl/srec_ctrl.sv
// ----------------------------------------------------------------------------
// srec_ctrl
// Sequencer that steps one cell through the shared multiplier and the
// level/total update registers of the datapath.
// ----------------------------------------------------------------------------
module srec_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srec_pkg::srec_sts_t sts_i,
  output srec_pkg::srec_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RW,
    ST_ETA1,
    ST_RVOL,
    ST_EW,
    ST_ETA2,
    ST_EVOL,
    ST_CLAMP,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.mul_sel = srec_pkg::MUL_RAIN_STEP;
        state_d       = ST_RW;
      end
      ST_RW: begin
        cmd_o.mul_sel = srec_pkg::MUL_RAIN_W;
        state_d       = ST_ETA1;
      end
      ST_ETA1: begin
        cmd_o.ld_eta1 = 1'b1;
        cmd_o.mul_sel = srec_pkg::MUL_EVAP_STEP;
        state_d       = ST_RVOL;
      end
      ST_RVOL: begin
        cmd_o.ld_ed   = 1'b1;
        cmd_o.mul_sel = srec_pkg::MUL_RAIN_VOL;
        state_d       = ST_EW;
      end
      ST_EW: begin
        cmd_o.upd_rain = 1'b1;
        cmd_o.mul_sel  = srec_pkg::MUL_EVAP_W;
        state_d        = ST_ETA2;
      end
      ST_ETA2: begin
        cmd_o.ld_eta2 = 1'b1;
        state_d       = ST_EVOL;
      end
      ST_EVOL: begin
        cmd_o.mul_sel = srec_pkg::MUL_EVAP_VOL;
        state_d       = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.upd_evap = 1'b1;
        cmd_o.mul_sel  = srec_pkg::MUL_CLAMP_VOL;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the word
        cmd_o.finish = !sts_i.out_busy;
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> hdl/srec_dp.sv
// ----------------------------------------------------------------------------
// srec_dp
// Configuration registers, cell registers, shared multiplier, saturating
// level and volume arithmetic, and the output register.
// ----------------------------------------------------------------------------
module srec_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srec_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [srec_pkg::CfgW-1:0]           cfg_data_i,
  input  logic signed [srec_pkg::LevelW-1:0]  surface_level_i,
  input  logic signed [srec_pkg::LevelW-1:0]  bed_level_i,
  input  logic [srec_pkg::WeightW-1:0]        rain_weight_i,
  input  logic [srec_pkg::WeightW-1:0]        evap_weight_i,
  input  srec_pkg::srec_cmd_t                 cmd_i,
  output srec_pkg::srec_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [srec_pkg::LevelW-1:0]  new_surface_level_o,
  output logic signed [srec_pkg::VolW-1:0]    rain_volume_o,
  output logic signed [srec_pkg::VolW-1:0]    evap_volume_o,
  output logic signed [srec_pkg::VolW-1:0]    clamp_volume_o
);

  // configuration
  logic signed [31:0] rain_rate_q, evap_rate_q, min_depth_q;
  logic        [30:0] time_step_q, cell_area_q;
  logic               evap_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rain_rate_q <= '0;
      evap_rate_q <= '0;
      time_step_q <= '0;
      min_depth_q <= '0;
      cell_area_q <= srec_pkg::CellAreaReset;
      evap_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srec_pkg::CFG_RAIN_RATE: rain_rate_q <= signed'(cfg_data_i);
        srec_pkg::CFG_EVAP_RATE: evap_rate_q <= signed'(cfg_data_i);
        srec_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[30:0];
        srec_pkg::CFG_MIN_DEPTH: min_depth_q <= signed'(cfg_data_i);
        srec_pkg::CFG_CELL_AREA: cell_area_q <= cfg_data_i[30:0];
        srec_pkg::CFG_EVAP_MODE: evap_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cell word
  logic signed [31:0] eta0_q, bed_q;
  logic        [16:0] rw_q, ew_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      eta0_q <= surface_level_i;
      bed_q  <= bed_level_i;
      rw_q   <= rain_weight_i;
      ew_q   <= evap_weight_i;
    end
  end

  // shared multiplier
  logic signed [64:0] p_q;
  logic signed [48:0] p_sh;
  logic signed [31:0] eta1_q, ed_q, eta2_q;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;

  assign p_sh = p_q[64:16];  // floor of the Q16 rescale

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      srec_pkg::MUL_RAIN_STEP: begin
        mul_a = 33'(rain_rate_q);
        mul_b = signed'({1'b0, time_step_q});
      end
      srec_pkg::MUL_RAIN_W: begin
        mul_a = 33'(srec_pkg::sat32(66'(p_sh)));
        mul_b = signed'({15'd0, rw_q});
      end
      srec_pkg::MUL_EVAP_STEP: begin
        mul_a = 33'(evap_rate_q);
        mul_b = signed'({1'b0, time_step_q});
      end
      srec_pkg::MUL_RAIN_VOL: begin
        mul_a = 33'(eta1_q) - 33'(eta0_q);
        mul_b = signed'({1'b0, cell_area_q});
      end
      srec_pkg::MUL_EVAP_W: begin
        mul_a = 33'(ed_q);
        mul_b = signed'({15'd0, ew_q});
      end
      srec_pkg::MUL_EVAP_VOL: begin
        mul_a = 33'(eta1_q) - 33'(eta2_q);
        mul_b = signed'({1'b0, cell_area_q});
      end
      srec_pkg::MUL_CLAMP_VOL: begin
        mul_a = 33'(bed_q) - 33'(eta2_q);
        mul_b = signed'({1'b0, cell_area_q});
      end
      default: ;
    endcase
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != srec_pkg::MUL_NONE) begin
      p_q <= prod;
    end
  end

  // level updates
  logic signed [32:0] depth, ed_ext, removed;
  logic signed [31:0] eta2_d;
  logic               clamp_q;

  assign depth   = 33'(eta1_q) - 33'(bed_q);
  assign ed_ext  = 33'(ed_q);
  assign removed = (ed_ext < depth) ? ed_ext : depth;

  always_comb begin
    if (evap_mode_q) begin
      eta2_d = (depth > 33'sd0) ? srec_pkg::sat32(66'(eta1_q) - 66'(removed)) : eta1_q;
    end else begin
      eta2_d = srec_pkg::sat32(66'(eta1_q) - 66'(p_sh));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_eta1) begin
      eta1_q <= srec_pkg::sat32(66'(eta0_q) + 66'(p_sh));
    end
    if (cmd_i.ld_ed) begin
      ed_q <= srec_pkg::sat32(66'(p_sh));
    end
    if (cmd_i.ld_eta2) begin
      eta2_q <= eta2_d;
    end
    if (cmd_i.upd_evap) begin
      clamp_q <= (34'(eta2_q) - 34'(bed_q)) < 34'(min_depth_q);
    end
  end

  // running totals
  logic signed [63:0] rain_total_q, evap_total_q, clamp_total_q, clamp_total_d;

  assign clamp_total_d = clamp_q ? srec_pkg::sat_add64(clamp_total_q, p_sh) : clamp_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rain_total_q  <= '0;
      evap_total_q  <= '0;
      clamp_total_q <= '0;
    end else begin
      if (cmd_i.upd_rain) begin
        rain_total_q <= srec_pkg::sat_add64(rain_total_q, p_sh);
      end
      if (cmd_i.upd_evap) begin
        evap_total_q <= srec_pkg::sat_add64(evap_total_q, p_sh);
      end
      if (cmd_i.finish) begin
        clamp_total_q <= clamp_total_d;
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      new_surface_level_o <= clamp_q ? bed_q : eta2_q;
      rain_volume_o       <= rain_total_q;
      evap_volume_o       <= evap_total_q;
      clamp_volume_o      <= clamp_total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

>>> hdl/srec_checker.sv
// ----------------------------------------------------------------------------
// srec_checker
// Port-level checks on the cell channels of the rain/evaporation block.
// ----------------------------------------------------------------------------
module srec_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [srec_pkg::LevelW-1:0] new_surface_level_i,
  input logic signed [srec_pkg::VolW-1:0]   rain_volume_i
);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(new_surface_level_i) && $stable(rain_volume_i))
    else $error("result payload changed while stalled");

  // one cell at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second cell taken while one is in flight");

  // a new result appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while a cell is still in flight");

endmodule

bind surface_rain_evap_clamp srec_checker u_srec_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_ch.valid),
  .in_ready_i          (in_ch.ready),
  .out_valid_i         (out_ch.valid),
  .out_ready_i         (out_ch.ready),
  .new_surface_level_i (out_ch.new_surface_level),
  .rain_volume_i       (out_ch.rain_volume)
);
